// File: hdl/escaped_binary_text_counter_macros.svh
// Assertion helpers used by the top-level RTL file.
`ifndef ESCAPED_BINARY_TEXT_COUNTER_MACROS_SVH
`define ESCAPED_BINARY_TEXT_COUNTER_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define EBTC_ASSERT_NOW(label, clk, rst_n, cond, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (expr)) \
        else $error("same-cycle check failed");

// Next-cycle implication, checked outside reset.
`define EBTC_ASSERT_NEXT(label, clk, rst_n, cond, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expr)) \
        else $error("next-cycle check failed");

`endif

// File: hdl/ebtc_pkg.sv
package ebtc_pkg;

    localparam int RESULT_BITS = 16;
    localparam int NUM_COUNTERS = 8;

    localparam logic [7:0] CH_BACKSLASH = 8'h5C;
    localparam logic [7:0] CH_X_LOWER   = 8'h78;
    localparam logic [7:0] CH_X_UPPER   = 8'h58;
    localparam logic [7:0] CH_ZERO      = 8'h30;
    localparam logic [7:0] CH_SEVEN     = 8'h37;
    localparam logic [7:0] CH_SPACE     = 8'h20;
    localparam logic [7:0] CH_TAB       = 8'h09;
    localparam logic [7:0] CH_LF        = 8'h0A;
    localparam logic [7:0] CH_CR        = 8'h0D;

    // Counter slots, also the order of the result fields from the low end.
    localparam int CNT_LETTER  = 0;
    localparam int CNT_SPACE   = 1;
    localparam int CNT_CONTROL = 2;
    localparam int CNT_VISIBLE = 3;
    localparam int CNT_ESCAPE  = 4;
    localparam int CNT_HEX     = 5;
    localparam int CNT_NULL    = 6;
    localparam int CNT_OCTAL   = 7;

    typedef enum logic [3:0] {
        PH_IDLE = 4'd0,
        PH_BSL  = 4'd1,
        PH_HEX0 = 4'd2,
        PH_HEX1 = 4'd3,
        PH_HEX2 = 4'd4,
        PH_NUL1 = 4'd5,
        PH_NUL2 = 4'd6,
        PH_OCT1 = 4'd7,
        PH_OCT2 = 4'd8
    } phase_t;

    typedef struct packed {
        logic visible;
        logic control;
        logic space;
        logic letter;
    } class_bits_t;

    // Increments that one transfer applies to the counter bank.
    typedef struct packed {
        logic [1:0] letter;
        logic [1:0] space;
        logic [1:0] control;
        logic [1:0] visible;
        logic       escape;
        logic       hex;
        logic       nul;
        logic       octal;
        logic       emit;
    } step_t;

    function automatic logic is_hex(input logic [7:0] b);
        return (b >= 8'h30 && b <= 8'h39) || (b >= 8'h41 && b <= 8'h46) ||
               (b >= 8'h61 && b <= 8'h66);
    endfunction

    function automatic logic is_oct(input logic [7:0] b);
        return b >= CH_ZERO && b <= CH_SEVEN;
    endfunction

    function automatic class_bits_t classify(input logic [7:0] b);
        class_bits_t c;
        c.letter  = (b >= 8'h41 && b <= 8'h5A) || (b >= 8'h61 && b <= 8'h7A);
        c.space   = (b == CH_SPACE) || (b >= CH_TAB && b <= CH_CR);
        c.control = (b < CH_SPACE) && (b != CH_LF) && (b != CH_CR) && (b != CH_TAB);
        c.visible = (b >= 8'h21 && b <= 8'h7E);
        return c;
    endfunction

    function automatic logic [1:0] count3(input logic a, input logic b, input logic c);
        return {1'b0, a} + {1'b0, b} + {1'b0, c};
    endfunction

endpackage

// File: hdl/ebtc_scan.sv
module ebtc_scan
    import ebtc_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       fire,
    input  logic [7:0] data_byte,
    input  logic       end_of_text,
    output step_t      step
);

    phase_t     phase_reg, phase_next, phase_mid;
    logic [7:0] held_reg, held_next, held_mid;
    logic       cls_x, cls_held, cls_byte, do_plain;
    logic       hit_hex, hit_nul, hit_oct;
    class_bits_t cb, cx, ch;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_IDLE;
            held_reg  <= '0;
        end else if (fire) begin
            phase_reg <= phase_next;
            held_reg  <= held_next;
        end
    end

    always_comb begin
        phase_mid = phase_reg;
        held_mid  = held_reg;
        cls_x     = 1'b0;
        cls_held  = 1'b0;
        cls_byte  = 1'b0;
        do_plain  = 1'b0;
        hit_hex   = 1'b0;
        hit_nul   = 1'b0;
        hit_oct   = 1'b0;

        unique case (phase_reg)
            PH_BSL: begin
                if (data_byte == CH_X_LOWER || data_byte == CH_X_UPPER) begin
                    phase_mid = PH_HEX0;
                end else if (data_byte == CH_ZERO) begin
                    phase_mid = PH_NUL1;
                end else if (is_oct(data_byte)) begin
                    phase_mid = PH_OCT1;
                    held_mid  = data_byte;
                end else begin
                    do_plain = 1'b1;
                end
            end
            PH_HEX0: begin
                if (is_hex(data_byte)) begin
                    phase_mid = PH_HEX1;
                    held_mid  = data_byte;
                end else begin
                    cls_x    = 1'b1;
                    do_plain = 1'b1;
                end
            end
            PH_HEX1: begin
                if (is_hex(data_byte)) begin
                    phase_mid = PH_HEX2;
                end else begin
                    cls_x    = 1'b1;
                    cls_held = 1'b1;
                    do_plain = 1'b1;
                end
            end
            PH_HEX2: begin
                if (!is_hex(data_byte)) begin
                    hit_hex  = 1'b1;
                    do_plain = 1'b1;
                end
            end
            PH_NUL1: begin
                if (is_oct(data_byte)) begin
                    phase_mid = PH_NUL2;
                end else begin
                    hit_nul  = 1'b1;
                    do_plain = 1'b1;
                end
            end
            PH_NUL2: begin
                hit_nul   = 1'b1;
                hit_oct   = 1'b1;
                phase_mid = PH_IDLE;
                do_plain  = !is_oct(data_byte);
            end
            PH_OCT1: begin
                if (is_oct(data_byte)) begin
                    phase_mid = PH_OCT2;
                end else begin
                    cls_held = 1'b1;
                    do_plain = 1'b1;
                end
            end
            PH_OCT2: begin
                hit_oct   = 1'b1;
                phase_mid = PH_IDLE;
                do_plain  = !is_oct(data_byte);
            end
            default: begin
                do_plain = 1'b1;
            end
        endcase

        // A backslash on the final byte is an ordinary visible byte.
        if (do_plain) begin
            if (data_byte == CH_BACKSLASH && !end_of_text) begin
                phase_mid = PH_BSL;
            end else begin
                phase_mid = PH_IDLE;
                cls_byte  = 1'b1;
            end
        end

        // Close an escape that is still open when the text ends.
        if (end_of_text) begin
            unique case (phase_mid)
                PH_HEX0: cls_x = 1'b1;
                PH_HEX1: begin
                    cls_x    = 1'b1;
                    cls_held = 1'b1;
                end
                PH_HEX2: hit_hex = 1'b1;
                PH_NUL1: hit_nul = 1'b1;
                PH_NUL2: begin
                    hit_nul = 1'b1;
                    hit_oct = 1'b1;
                end
                PH_OCT1: cls_held = 1'b1;
                PH_OCT2: hit_oct = 1'b1;
                default: ;
            endcase
        end

        phase_next = end_of_text ? PH_IDLE : phase_mid;
        held_next  = end_of_text ? 8'h00 : held_mid;
    end

    assign cb = classify(data_byte);
    assign cx = classify(CH_X_LOWER);
    assign ch = classify(held_mid);

    assign step.letter  = count3(cls_x & cx.letter,  cls_held & ch.letter,  cls_byte & cb.letter);
    assign step.space   = count3(cls_x & cx.space,   cls_held & ch.space,   cls_byte & cb.space);
    assign step.control = count3(cls_x & cx.control, cls_held & ch.control,
                                 cls_byte & cb.control);
    assign step.visible = count3(cls_x & cx.visible, cls_held & ch.visible,
                                 cls_byte & cb.visible);
    assign step.escape  = hit_hex | hit_nul | hit_oct;
    assign step.hex     = hit_hex;
    assign step.nul     = hit_nul;
    assign step.octal   = hit_oct;
    assign step.emit    = end_of_text;

endmodule

// File: hdl/ebtc_count_bank.sv
module ebtc_count_bank
    import ebtc_pkg::*;
#(
    parameter int COUNT_BITS = 16
) (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   fire,
    input  step_t                                  step,
    output logic [NUM_COUNTERS-1:0][RESULT_BITS-1:0] result
);

    localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;

    logic [COUNT_BITS-1:0] cnt_reg [NUM_COUNTERS];
    logic [COUNT_BITS-1:0] sat     [NUM_COUNTERS];
    logic [COUNT_BITS:0]   sum     [NUM_COUNTERS];
    logic [1:0]            inc     [NUM_COUNTERS];

    always_comb begin
        inc[CNT_LETTER]  = step.letter;
        inc[CNT_SPACE]   = step.space;
        inc[CNT_CONTROL] = step.control;
        inc[CNT_VISIBLE] = step.visible;
        inc[CNT_ESCAPE]  = {1'b0, step.escape};
        inc[CNT_HEX]     = {1'b0, step.hex};
        inc[CNT_NULL]    = {1'b0, step.nul};
        inc[CNT_OCTAL]   = {1'b0, step.octal};
    end

    // An increment is at most three, so a carry out means the counter passed its top.
    always_comb begin
        for (int k = 0; k < NUM_COUNTERS; k++) begin
            sum[k] = {1'b0, cnt_reg[k]} + (COUNT_BITS + 1)'(inc[k]);
            sat[k] = sum[k][COUNT_BITS] ? CNT_MAX : sum[k][COUNT_BITS-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k < NUM_COUNTERS; k++) begin
                cnt_reg[k] <= '0;
            end
        end else if (fire) begin
            for (int k = 0; k < NUM_COUNTERS; k++) begin
                cnt_reg[k] <= step.emit ? '0 : sat[k];
            end
        end
    end

    for (genvar k = 0; k < NUM_COUNTERS; k++) begin : g_result
        if (COUNT_BITS >= RESULT_BITS) begin : g_cut
            assign result[k] = sat[k][RESULT_BITS-1:0];
        end else begin : g_ext
            assign result[k] = {{(RESULT_BITS - COUNT_BITS){1'b0}}, sat[k]};
        end
    end

endmodule

// File: hdl/escaped_binary_text_counter.sv
// Text statistics counter with backslash-escape recognition.
// Input stream: one text byte per transfer on s_tdata, s_tlast on the final
// byte of a text. Output stream: one transfer per text, carrying the eight
// saturating counts (letters, whitespace, control, visible, escapes, hex,
// null and octal escapes), 16 bits each.
// Throughput is one byte per cycle: the escape state and the counter bank
// update in a single pass between the input register and the result
// register. m_tvalid rises when the final byte's counts load the result register.
// While a result waits for m_tready, bytes of the next text keep flowing;
// only a second final byte stalls in the input register until the pending
// result is taken, and s_tready then drops.
// Reset (aresetn low, synchronous) empties both registers, returns the
// escape scanner to idle and clears all counters. After each result the
// counters and scanner restart from zero for the next text.
`include "escaped_binary_text_counter_macros.svh"

module escaped_binary_text_counter
    import ebtc_pkg::*;
#(
    parameter int COUNT_BITS = 16
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [7:0]   s_tdata,   // [7:0] data_byte
    input  logic         s_tlast,   // end_of_text
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [127:0] m_tdata    // letter, space, control, visible, escape,
                                    // hex_escape, null_escape, octal_escape counts,
                                    // 16 bits each from the low end
);

    logic       in_valid_reg;
    logic [7:0] in_byte_reg;
    logic       in_last_reg;
    logic       fire;
    logic       m_valid_reg;
    logic [NUM_COUNTERS-1:0][RESULT_BITS-1:0] m_data_reg;
    logic [NUM_COUNTERS-1:0][RESULT_BITS-1:0] result;
    step_t      step;

    // A byte that produces no result never waits on the output side.
    assign fire     = in_valid_reg && (!in_last_reg || !m_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || fire;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_byte_reg <= s_tdata;
            in_last_reg <= s_tlast;
        end
    end

    ebtc_scan u_scan (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .fire        (fire),
        .data_byte   (in_byte_reg),
        .end_of_text (in_last_reg),
        .step        (step)
    );

    ebtc_count_bank #(
        .COUNT_BITS (COUNT_BITS)
    ) u_count_bank (
        .aclk    (aclk),
        .aresetn (aresetn),
        .fire    (fire),
        .step    (step),
        .result  (result)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (fire && in_last_reg) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (fire && in_last_reg) begin
            m_data_reg <= result;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    `EBTC_ASSERT_NEXT(a_result_loaded, aclk, aresetn, fire && in_last_reg, m_valid_reg)
    `EBTC_ASSERT_NOW(a_no_overwrite, aclk, aresetn, m_valid_reg && !m_tready,
                     !(fire && in_last_reg))
    `EBTC_ASSERT_NOW(a_plain_byte_flows, aclk, aresetn, in_valid_reg && !in_last_reg, s_tready)

endmodule
